// ===== src/chtg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtg_pkg
// shared types, constants and the quarter wave sine polynomial
// ----------------------------------------------------------------------------
package chtg_pkg;

  localparam int SINE_TABLE_DEPTH_DEFAULT = 256;
  localparam int POS_FRAC_BITS_DEFAULT    = 4;

  localparam int Q14_ONE   = 16384;
  localparam int FRAC_FORE = 42598;
  localparam int FRAC_AFT  = 22938;

  localparam logic [31:0] WHITE_RGBA = 32'hFFFF_FFFF;
  localparam logic [9:0]  UNIT_SCALE = 10'd256;

  // configuration register indexes
  localparam logic [2:0] REG_VIEW_WIDTH  = 3'd0;
  localparam logic [2:0] REG_VIEW_HEIGHT = 3'd1;
  localparam logic [2:0] REG_CULL_MARGIN = 3'd2;
  localparam logic [2:0] REG_MARKER_LEN  = 3'd3;
  localparam logic [2:0] REG_MARKER_HW   = 3'd4;
  localparam logic [2:0] REG_OUTLINE     = 3'd5;
  localparam logic [2:0] REG_NORMAL_COL  = 3'd6;
  localparam logic [2:0] REG_ALERT_COL   = 3'd7;

  // draw groups
  localparam logic [1:0] GRP_NORMAL   = 2'd0;
  localparam logic [1:0] GRP_ALERT    = 2'd1;
  localparam logic [1:0] GRP_OUTLINE  = 2'd2;
  localparam logic [1:0] GRP_SEL_BODY = 2'd3;

  // arrowhead points
  localparam logic [1:0] PT_NOSE  = 2'd0;
  localparam logic [1:0] PT_LEFT  = 2'd1;
  localparam logic [1:0] PT_RIGHT = 2'd2;

  // classified marker, front to back
  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] sn;
    logic signed [15:0] cs;
    logic               alert;
    logic               selected;
  } chtg_item_t;

  // per vertex data carried down the vertex pipeline
  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] sn;
    logic signed [15:0] cs;
    logic [31:0]        color;
    logic [1:0]         group;
    logic               last;
    logic [1:0]         pt;
  } chtg_side_t;

  // q14 sine on the quarter wave, only ever called with constant arguments
  function automatic logic [14:0] quarter_sine(longint x);
    longint x2;
    longint t;
    x2 = (x * x) >>> 14;
    t  = (longint'(1160) * x2) >>> 14;
    t  = longint'(10512) - t;
    t  = (t * x2) >>> 14;
    t  = longint'(25736) - t;
    t  = (t * x) >>> 14;
    if (t < 0) t = 0;
    if (t > longint'(Q14_ONE)) t = longint'(Q14_ONE);
    return t[14:0];
  endfunction

endpackage

// ===== src/chtg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtg_front
// input stage: culling, heading choice and sine/cosine lookup
// ----------------------------------------------------------------------------
module chtg_front #(
  parameter int SINE_TABLE_DEPTH = chtg_pkg::SINE_TABLE_DEPTH_DEFAULT,
  parameter int POS_FRAC_BITS    = chtg_pkg::POS_FRAC_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [15:0]   pos_x,
  input  logic signed [15:0]   pos_y,
  input  logic                 pos_valid,
  input  logic [15:0]          heading_angle,
  input  logic                 heading_present,
  input  logic [15:0]          course_angle,
  input  logic                 course_present,
  input  logic                 is_alert,
  input  logic                 is_selected,
  input  logic [11:0]          view_width,
  input  logic [11:0]          view_height,
  input  logic [11:0]          cull_margin,
  output logic                 push,
  input  logic                 full,
  output chtg_pkg::chtg_item_t push_item
);

  localparam int LD  = $clog2(SINE_TABLE_DEPTH);
  localparam int QTR = SINE_TABLE_DEPTH / 4;
  localparam int LW  = 13 + POS_FRAC_BITS + 1;

  logic                 s1_valid;
  logic signed [15:0]   r_x;
  logic signed [15:0]   r_y;
  logic                 r_pv;
  logic [15:0]          r_head;
  logic                 r_hp;
  logic [15:0]          r_course;
  logic                 r_cp;
  logic                 r_alert;
  logic                 r_sel;

  logic [14:0]          qtab [QTR+1];
  logic signed [LW-1:0] lo_lim;
  logic signed [LW-1:0] w_lim;
  logic signed [LW-1:0] h_lim;
  logic signed [LW-1:0] px;
  logic signed [LW-1:0] py;
  logic                 keep;
  logic                 done;
  logic [15:0]          angle;
  logic [LD-1:0]        st_s;
  logic [LD-1:0]        st_c;
  logic [LD-2:0]        idx_s;
  logic [LD-2:0]        idx_c;
  logic [14:0]          mag_s;
  logic [14:0]          mag_c;

  // quarter wave table, folded to constants
  for (genvar g = 0; g <= QTR; g++) begin : g_tab
    assign qtab[g] = chtg_pkg::quarter_sine(longint'(g) * 65536 / SINE_TABLE_DEPTH);
  end

  always_comb begin
    lo_lim = -LW'($signed({1'b0, cull_margin}));
    w_lim  = LW'($signed({1'b0, view_width})) <<< POS_FRAC_BITS;
    w_lim  = w_lim + LW'($signed({1'b0, cull_margin}));
    h_lim  = LW'($signed({1'b0, view_height})) <<< POS_FRAC_BITS;
    h_lim  = h_lim + LW'($signed({1'b0, cull_margin}));
    px     = LW'(r_x);
    py     = LW'(r_y);
    keep   = r_pv && (view_width != '0) && (view_height != '0) &&
             (px >= lo_lim) && (px <= w_lim) && (py >= lo_lim) && (py <= h_lim);

    angle = r_hp ? r_head : 16'd0;
    if (angle == 16'd0 && r_cp) angle = r_course;

    st_s  = angle[15 -: LD];
    st_c  = st_s + LD'(QTR);
    idx_s = st_s[LD-2] ? (LD-1)'(QTR) - {1'b0, st_s[LD-3:0]} : {1'b0, st_s[LD-3:0]};
    idx_c = st_c[LD-2] ? (LD-1)'(QTR) - {1'b0, st_c[LD-3:0]} : {1'b0, st_c[LD-3:0]};
    mag_s = qtab[idx_s];
    mag_c = qtab[idx_c];

    push_item.cx       = r_x;
    push_item.cy       = r_y;
    push_item.sn       = st_s[LD-1] ? -$signed({1'b0, mag_s}) : $signed({1'b0, mag_s});
    push_item.cs       = st_c[LD-1] ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
    push_item.alert    = r_alert;
    push_item.selected = r_sel;

    push     = s1_valid && keep && !full;
    done     = !keep || !full;
    in_ready = !s1_valid || done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      r_x      <= pos_x;
      r_y      <= pos_y;
      r_pv     <= pos_valid;
      r_head   <= heading_angle;
      r_hp     <= heading_present;
      r_course <= course_angle;
      r_cp     <= course_present;
      r_alert  <= is_alert;
      r_sel    <= is_selected;
    end
  end

endmodule

// ===== src/chtg_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtg_queue
// two entry queue of classified markers
// ----------------------------------------------------------------------------
module chtg_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  chtg_pkg::chtg_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 q_valid,
  output chtg_pkg::chtg_item_t q_item
);

  chtg_pkg::chtg_item_t mem [2];
  logic [1:0]           count;
  logic                 wr;
  logic                 rd;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item  = mem[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wr    <= 1'b0;
      rd    <= 1'b0;
    end else begin
      if (push) wr <= ~wr;
      if (pop)  rd <= ~rd;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem[wr] <= push_item;
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
`endif

endmodule

// ===== src/chtg_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtg_back
// vertex sequencer and rotation pipeline, one vertex per cycle unless the output stalls
// ----------------------------------------------------------------------------
module chtg_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  chtg_pkg::chtg_item_t q_item,
  output logic                 pop,
  input  logic [9:0]           marker_length,
  input  logic [9:0]           marker_half_width,
  input  logic [9:0]           outline_scale,
  input  logic [31:0]          normal_color,
  input  logic [31:0]          alert_color,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [63:0]          m_tdata,
  output logic [1:0]           m_tuser,
  output logic                 m_tlast
);

  logic                       en;
  logic [2:0]                 cnt;
  logic                       tri_last;
  logic                       outline;
  chtg_pkg::chtg_side_t       a_side_next;

  logic                       a_valid, b_valid, c_valid, d_valid, e_valid;
  chtg_pkg::chtg_side_t       a_side, b_side, c_side, d_side, e_side;
  logic [9:0]                 a_scale;
  logic [19:0]                b_ls;
  logic [19:0]                b_hs;
  logic signed [37:0]         c_ly;
  logic signed [20:0]         c_hx;
  logic signed [36:0]         d_pxc;
  logic signed [36:0]         d_pxs;
  logic signed [53:0]         d_pyc;
  logic signed [53:0]         d_pys;
  logic signed [15:0]         e_rx;
  logic signed [15:0]         e_ry;

  logic signed [37:0]         sls;
  logic signed [54:0]         rx_sum;
  logic signed [54:0]         ry_sum;
  logic [54:0]                rx_mag;
  logic [54:0]                ry_mag;
  logic [16:0]                rx_rnd;
  logic [16:0]                ry_rnd;
  logic signed [16:0]         sx;
  logic signed [16:0]         sy;

  assign en = !m_tvalid || m_tready;

  // sequencer: outline triangle first for a selected marker, then the body
  always_comb begin
    outline  = q_item.selected && (cnt < 3'd3);
    tri_last = (cnt == 3'd2 && !q_item.selected) || (cnt == 3'd5);
    pop      = en && q_valid && tri_last;

    a_side_next.cx    = q_item.cx;
    a_side_next.cy    = q_item.cy;
    a_side_next.sn    = q_item.sn;
    a_side_next.cs    = q_item.cs;
    a_side_next.color = outline ? chtg_pkg::WHITE_RGBA :
                        (q_item.alert ? alert_color : normal_color);
    if (outline) a_side_next.group = chtg_pkg::GRP_OUTLINE;
    else if (q_item.selected) a_side_next.group = chtg_pkg::GRP_SEL_BODY;
    else if (q_item.alert) a_side_next.group = chtg_pkg::GRP_ALERT;
    else a_side_next.group = chtg_pkg::GRP_NORMAL;
    a_side_next.last = tri_last;
    a_side_next.pt   = (cnt >= 3'd3) ? 2'(cnt - 3'd3) : cnt[1:0];
  end

  always_comb begin
    sls = 38'($signed({1'b0, b_ls}));

    rx_sum = (55'(d_pxc) <<< 16) - 55'(d_pys);
    ry_sum = (55'(d_pxs) <<< 16) + 55'(d_pyc);
    rx_mag = rx_sum[54] ? 55'(-rx_sum) : 55'(rx_sum);
    ry_mag = ry_sum[54] ? 55'(-ry_sum) : 55'(ry_sum);
    rx_rnd = 17'((rx_mag + (55'd1 << 37)) >> 38);
    ry_rnd = 17'((ry_mag + (55'd1 << 37)) >> 38);

    sx = 17'(e_side.cx) + 17'(e_rx);
    sy = 17'(e_side.cy) + 17'(e_ry);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= 3'd0;
      a_valid  <= 1'b0;
      b_valid  <= 1'b0;
      c_valid  <= 1'b0;
      d_valid  <= 1'b0;
      e_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      if (q_valid) cnt <= tri_last ? 3'd0 : cnt + 3'd1;
      a_valid  <= q_valid;
      b_valid  <= a_valid;
      c_valid  <= b_valid;
      d_valid  <= c_valid;
      e_valid  <= d_valid;
      m_tvalid <= e_valid;
    end
    if (en) begin
      // a: pick scale
      a_side  <= a_side_next;
      a_scale <= outline ? outline_scale : chtg_pkg::UNIT_SCALE;
      // b: scaled length and half width
      b_side  <= a_side;
      b_ls    <= 20'(marker_length) * 20'(a_scale);
      b_hs    <= 20'(marker_half_width) * 20'(a_scale);
      // c: local point
      c_side  <= b_side;
      case (b_side.pt)
        chtg_pkg::PT_NOSE: begin
          c_ly <= -(sls * 38'sd42598);
          c_hx <= 21'sd0;
        end
        chtg_pkg::PT_LEFT: begin
          c_ly <= sls * 38'sd22938;
          c_hx <= -21'($signed({1'b0, b_hs}));
        end
        default: begin
          c_ly <= sls * 38'sd22938;
          c_hx <= 21'($signed({1'b0, b_hs}));
        end
      endcase
      // d: rotation products
      d_side <= c_side;
      d_pxc  <= 37'(c_hx) * 37'(c_side.cs);
      d_pxs  <= 37'(c_hx) * 37'(c_side.sn);
      d_pyc  <= 54'(c_ly) * 54'(c_side.cs);
      d_pys  <= 54'(c_ly) * 54'(c_side.sn);
      // e: round half away from zero
      e_side <= d_side;
      e_rx   <= rx_sum[54] ? -$signed(16'(rx_rnd)) : $signed(16'(rx_rnd));
      e_ry   <= ry_sum[54] ? -$signed(16'(ry_rnd)) : $signed(16'(ry_rnd));
      // output: offset and saturate
      if (sx > 17'sd32767)       m_tdata[15:0] <= 16'h7FFF;
      else if (sx < -17'sd32768) m_tdata[15:0] <= 16'h8000;
      else                       m_tdata[15:0] <= sx[15:0];
      if (sy > 17'sd32767)       m_tdata[31:16] <= 16'h7FFF;
      else if (sy < -17'sd32768) m_tdata[31:16] <= 16'h8000;
      else                       m_tdata[31:16] <= sy[15:0];
      m_tdata[63:32] <= e_side.color;
      m_tuser        <= e_side.group;
      m_tlast        <= e_side.last;
    end
  end

`ifndef SYNTH
  a_outline_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == chtg_pkg::GRP_OUTLINE |-> !m_tlast)
    else $error("outline vertex marked last");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= 3'd5)
    else $error("vertex counter out of range");
  a_cnt_plain: assert property (@(posedge clk) disable iff (rst)
    q_valid && !q_item.selected |-> cnt <= 3'd2)
    else $error("plain marker past its third vertex");
  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> a_valid && a_side.last)
    else $error("queue pop without last vertex issued");
`endif

endmodule

// ===== src/culled_heading_triangle_gen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// culled_heading_triangle_gen
// culls markers against the view and emits rotated arrowhead vertices
// ----------------------------------------------------------------------------
// Each marker request on the slave side either vanishes (invalid position,
// zero-sized view, or outside the view plus margin) or produces three
// vertices, six for a selected marker (white outline first, then the body).
// Vertices leave one per cycle from a six stage rotation pipeline while the
// master side does not stall; a culled marker is dropped in the input stage
// and never reaches the vertex pipeline. A two entry queue sits between
// culling and vertex generation, so input keeps flowing while vertices drain
// or the master side stalls, until the queue is full. Configuration is
// written through cfg_we/cfg_addr/cfg_wdata and must only change while idle.
// ----------------------------------------------------------------------------
module culled_heading_triangle_gen #(
  parameter int SINE_TABLE_DEPTH       = chtg_pkg::SINE_TABLE_DEPTH_DEFAULT,
  parameter int POSITION_FRACTION_BITS = chtg_pkg::POS_FRAC_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // marker requests
  input  logic        s_tvalid,
  output logic        s_tready,
  // pos_x[15:0], pos_y[31:16], pos_valid[32], heading_angle[48:33],
  // heading_present[49], course_angle[65:50], course_present[66],
  // is_alert[67], is_selected[68], zero fill above
  input  logic [71:0] s_tdata,
  // vertex results
  output logic        m_tvalid,
  input  logic        m_tready,
  // vertex_x[15:0], vertex_y[31:16], vertex_color[63:32]
  output logic [63:0] m_tdata,
  // draw_group[1:0]
  output logic [1:0]  m_tuser,
  // last_vertex
  output logic        m_tlast,
  // configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  // config registers
  logic [11:0] view_width;
  logic [11:0] view_height;
  logic [11:0] cull_margin;
  logic [9:0]  marker_length;
  logic [9:0]  marker_half_width;
  logic [9:0]  outline_scale;
  logic [31:0] normal_color;
  logic [31:0] alert_color;

  logic                 push;
  logic                 full;
  logic                 pop;
  logic                 q_valid;
  chtg_pkg::chtg_item_t push_item;
  chtg_pkg::chtg_item_t q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_width        <= 12'd0;
      view_height       <= 12'd0;
      cull_margin       <= 12'd384;
      marker_length     <= 10'd240;
      marker_half_width <= 10'd88;
      outline_scale     <= 10'd346;
      normal_color      <= 32'h06B6_D4FF;
      alert_color       <= 32'hEF44_44FF;
    end else if (cfg_we) begin
      case (cfg_addr)
        chtg_pkg::REG_VIEW_WIDTH:  view_width        <= cfg_wdata[11:0];
        chtg_pkg::REG_VIEW_HEIGHT: view_height       <= cfg_wdata[11:0];
        chtg_pkg::REG_CULL_MARGIN: cull_margin       <= cfg_wdata[11:0];
        chtg_pkg::REG_MARKER_LEN:  marker_length     <= cfg_wdata[9:0];
        chtg_pkg::REG_MARKER_HW:   marker_half_width <= cfg_wdata[9:0];
        chtg_pkg::REG_OUTLINE:     outline_scale     <= cfg_wdata[9:0];
        chtg_pkg::REG_NORMAL_COL:  normal_color      <= cfg_wdata;
        chtg_pkg::REG_ALERT_COL:   alert_color       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // culling, heading choice, sine/cosine
  chtg_front #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .POS_FRAC_BITS    (POSITION_FRACTION_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .pos_x           ($signed(s_tdata[15:0])),
    .pos_y           ($signed(s_tdata[31:16])),
    .pos_valid       (s_tdata[32]),
    .heading_angle   (s_tdata[48:33]),
    .heading_present (s_tdata[49]),
    .course_angle    (s_tdata[65:50]),
    .course_present  (s_tdata[66]),
    .is_alert        (s_tdata[67]),
    .is_selected     (s_tdata[68]),
    .view_width      (view_width),
    .view_height     (view_height),
    .cull_margin     (cull_margin),
    .push            (push),
    .full            (full),
    .push_item       (push_item)
  );

  // decouples culling from vertex output
  chtg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  // vertex sequencing and rotation
  chtg_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .pop               (pop),
    .marker_length     (marker_length),
    .marker_half_width (marker_half_width),
    .outline_scale     (outline_scale),
    .normal_color      (normal_color),
    .alert_color       (alert_color),
    .m_tvalid          (m_tvalid),
    .m_tready          (m_tready),
    .m_tdata           (m_tdata),
    .m_tuser           (m_tuser),
    .m_tlast           (m_tlast)
  );

endmodule

// ===== tb/chtg_vertex_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtg_vertex_checker
// predicts arrowhead vertices for each accepted marker and compares them
// ----------------------------------------------------------------------------
module chtg_vertex_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [71:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        m_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          pending_vertices
);

  typedef struct {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic [31:0]        color;
    logic [1:0]         group;
    logic               last;
  } vertex_t;

  vertex_t vertex_queue[$];

  logic [11:0] view_w, view_h, margin;
  logic [9:0]  mlen, mhw, oscale;
  logic [31:0] ncol, acol;

  function automatic longint poly_q14(longint x);
    longint x2, t;
    x2 = (x * x) >>> 14;
    t = 10512 - ((1160 * x2) >>> 14);
    t = 25736 - ((t * x2) >>> 14);
    t = (t * x) >>> 14;
    if (t < 0) t = 0;
    if (t > 16384) t = 16384;
    return t;
  endfunction

  function automatic longint sine_of(logic [15:0] ph);
    longint s;
    s = ph[14] ? poly_q14(16384 - longint'(ph[13:0])) : poly_q14(longint'(ph[13:0]));
    return ph[15] ? -s : s;
  endfunction

  function automatic longint round38(longint v);
    if (v >= 0) return (v + (64'sd1 <<< 37)) >>> 38;
    return -((-v + (64'sd1 <<< 37)) >>> 38);
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  task automatic push_arrowhead(longint cx, longint cy, longint sn, longint cs,
                                longint scale, logic [31:0] col, logic [1:0] grp,
                                logic fin);
    longint ls, hs, rx, ry;
    longint lx[3], ly[3];
    vertex_t v;
    ls = longint'(mlen) * scale;
    hs = longint'(mhw) * scale;
    lx[0] = 0;           ly[0] = -(ls * chtg_pkg::FRAC_FORE);
    lx[1] = -(hs * 65536); ly[1] = ls * chtg_pkg::FRAC_AFT;
    lx[2] = hs * 65536;  ly[2] = ls * chtg_pkg::FRAC_AFT;
    for (int k = 0; k < 3; k++) begin
      rx = round38(lx[k] * cs - ly[k] * sn);
      ry = round38(lx[k] * sn + ly[k] * cs);
      v.vx = clamp16(cx + rx);
      v.vy = clamp16(cy + ry);
      v.color = col;
      v.group = grp;
      v.last = fin && (k == 2);
      vertex_queue.push_back(v);
    end
  endtask

  task automatic predict_marker(logic [71:0] d);
    longint cx, cy, wl, hl, sn, cs;
    logic [15:0] ang, ph;
    logic [31:0] col;
    cx = longint'($signed(d[15:0]));
    cy = longint'($signed(d[31:16]));
    if (!d[32] || view_w == 0 || view_h == 0) return;
    wl = (longint'(view_w) << 4) + margin;
    hl = (longint'(view_h) << 4) + margin;
    if (cx < -longint'(margin) || cx > wl || cy < -longint'(margin) || cy > hl) return;
    ang = d[49] ? d[48:33] : 16'd0;
    if (ang == 0 && d[66]) ang = d[65:50];
    // quantize to 256 steps per turn
    ph = {ang[15:8], 8'd0};
    sn = sine_of(ph);
    cs = sine_of(ph + 16'h4000);
    col = d[67] ? acol : ncol;
    if (d[68]) begin
      push_arrowhead(cx, cy, sn, cs, oscale, chtg_pkg::WHITE_RGBA,
                     chtg_pkg::GRP_OUTLINE, 1'b0);
      push_arrowhead(cx, cy, sn, cs, chtg_pkg::UNIT_SCALE, col,
                     chtg_pkg::GRP_SEL_BODY, 1'b1);
    end else begin
      push_arrowhead(cx, cy, sn, cs, chtg_pkg::UNIT_SCALE, col,
                     d[67] ? chtg_pkg::GRP_ALERT : chtg_pkg::GRP_NORMAL, 1'b1);
    end
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    vertex_t e;
    if (rst) begin
      fail_count = 0;
      view_w <= 0; view_h <= 0; margin <= 384; mlen <= 240; mhw <= 88;
      oscale <= 346; ncol <= 32'h06B6D4FF; acol <= 32'hEF4444FF;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          chtg_pkg::REG_VIEW_WIDTH:  view_w <= cfg_wdata[11:0];
          chtg_pkg::REG_VIEW_HEIGHT: view_h <= cfg_wdata[11:0];
          chtg_pkg::REG_CULL_MARGIN: margin <= cfg_wdata[11:0];
          chtg_pkg::REG_MARKER_LEN:  mlen <= cfg_wdata[9:0];
          chtg_pkg::REG_MARKER_HW:   mhw <= cfg_wdata[9:0];
          chtg_pkg::REG_OUTLINE:     oscale <= cfg_wdata[9:0];
          chtg_pkg::REG_NORMAL_COL:  ncol <= cfg_wdata;
          chtg_pkg::REG_ALERT_COL:   acol <= cfg_wdata;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_marker(s_tdata);
      if (m_tvalid && m_tready) begin
        if (vertex_queue.size() == 0) begin
          report_mismatch("vertex with none expected");
        end else begin
          e = vertex_queue.pop_front();
          if (m_tdata[15:0] !== e.vx)
            report_mismatch($sformatf("x got %0d exp %0d", $signed(m_tdata[15:0]), e.vx));
          if (m_tdata[31:16] !== e.vy)
            report_mismatch($sformatf("y got %0d exp %0d", $signed(m_tdata[31:16]), e.vy));
          if (m_tdata[63:32] !== e.color)
            report_mismatch($sformatf("color got %h exp %h", m_tdata[63:32], e.color));
          if (m_tuser !== e.group)
            report_mismatch($sformatf("group got %0d exp %0d", m_tuser, e.group));
          if (m_tlast !== e.last)
            report_mismatch($sformatf("last got %0b exp %0b", m_tlast, e.last));
        end
      end
    end
    pending_vertices = vertex_queue.size();
  end
endmodule

// ===== tb/tb_culled_heading_triangle_gen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_culled_heading_triangle_gen
// marker stream stimulus across several register settings, checked per vertex
// ----------------------------------------------------------------------------
module tb_culled_heading_triangle_gen;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we = 0;
  logic [2:0]  cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;
  int          fail_count;
  int          pending_vertices;

  always #2 clk = ~clk;

  culled_heading_triangle_gen uut (.*);
  chtg_vertex_checker checker_i (.*);

  // receiver: random stall before each vertex, with stall-free stretches
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        m_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic write_reg(logic [2:0] a, logic [31:0] v);
    cfg_we <= 1; cfg_addr <= a; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // one marker request, with an optional idle gap before it
  task automatic send_marker(logic signed [15:0] x, logic signed [15:0] y, logic pv,
                             logic [15:0] hd, logic hp, logic [15:0] co, logic cp,
                             logic al, logic sel, bit gaps);
    int gap;
    gap = gaps ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11)) : 0;
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {3'b0, sel, al, cp, co, hp, hd, pv, y, x};
    do @(posedge clk); while (!s_tready);
  endtask

  // wait for a clock edge first so the last accepted request is already predicted
  task automatic drain_idle();
    s_tvalid <= 0;
    @(posedge clk);
    while (pending_vertices != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // mostly in-view positions near the view, some anywhere
  function automatic logic [15:0] pick_coord(int lim);
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    return 16'($urandom_range(0, lim + 800) - 400);
  endfunction

  task automatic random_markers(int n, int wl, int hl);
    logic [15:0] hd;
    for (int i = 0; i < n; i++) begin
      hd = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom);
      send_marker(pick_coord(wl), pick_coord(hl), $urandom_range(0, 7) != 0, hd,
                  1'($urandom_range(0, 1)), 16'($urandom), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), i % 40 >= 10);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // zero view at reset: nothing comes out
    send_marker(16'sd100, 16'sd100, 1, 16'd0, 0, 16'd0, 0, 0, 0, 0);
    drain_idle();
    write_reg(chtg_pkg::REG_VIEW_WIDTH, 32'd100);
    write_reg(chtg_pkg::REG_VIEW_HEIGHT, 32'd80);
    // heading choice, culling edges, flags
    send_marker(16'sd800, 16'sd640, 1, 16'h4000, 1, 16'h8000, 1, 0, 0, 0);
    send_marker(16'sd800, 16'sd640, 1, 16'h0000, 1, 16'h8000, 1, 1, 0, 0);
    send_marker(16'sd800, 16'sd640, 1, 16'h0000, 0, 16'hC000, 0, 0, 1, 0);
    send_marker(16'sd800, 16'sd640, 1, 16'hFFFF, 1, 16'h1234, 1, 1, 1, 0);
    send_marker(16'sd800, 16'sd640, 1, 16'h00FF, 1, 16'h0000, 0, 0, 0, 0);
    send_marker(16'sd800, 16'sd640, 0, 16'h4000, 1, 16'h0000, 0, 0, 0, 0);
    send_marker(-16'sd384, -16'sd384, 1, 16'h2000, 1, 16'h0, 0, 0, 0, 0);
    send_marker(-16'sd385, 16'sd0, 1, 16'h2000, 1, 16'h0, 0, 0, 0, 0);
    send_marker(16'sd1984, 16'sd1664, 1, 16'h6000, 1, 16'h0, 0, 0, 1, 0);
    send_marker(16'sd1985, 16'sd0, 1, 16'h6000, 1, 16'h0, 0, 0, 0, 0);
    send_marker(16'sd0, 16'sd1665, 1, 16'h6000, 1, 16'h0, 0, 0, 0, 0);
    send_marker(16'sh7fff, 16'sh8000, 1, 16'hAAAA, 1, 16'h5555, 1, 1, 1, 0);
    drain_idle();
    // huge view, max marker and outline: saturation at the range ends
    write_reg(chtg_pkg::REG_VIEW_WIDTH, 32'hFFF);
    write_reg(chtg_pkg::REG_VIEW_HEIGHT, 32'hFFF);
    write_reg(chtg_pkg::REG_CULL_MARGIN, 32'hFFF);
    write_reg(chtg_pkg::REG_MARKER_LEN, 32'h3FF);
    write_reg(chtg_pkg::REG_MARKER_HW, 32'h3FF);
    write_reg(chtg_pkg::REG_OUTLINE, 32'h3FF);
    write_reg(chtg_pkg::REG_NORMAL_COL, 32'hFFFFFFFF);
    write_reg(chtg_pkg::REG_ALERT_COL, 32'h00000000);
    send_marker(16'sh7fff, 16'sh7fff, 1, 16'h8000, 1, 16'h0, 0, 0, 1, 0);
    send_marker(16'sh8000, 16'sh8000, 1, 16'h0000, 1, 16'h0, 0, 1, 1, 0);
    send_marker(16'sd0, 16'sh7fff, 1, 16'hE000, 1, 16'h0, 0, 1, 0, 0);
    random_markers(60, 65535, 65535);
    drain_idle();
    // small marker, zero outline, random colors
    write_reg(chtg_pkg::REG_VIEW_WIDTH, 32'd640);
    write_reg(chtg_pkg::REG_VIEW_HEIGHT, 32'd480);
    write_reg(chtg_pkg::REG_CULL_MARGIN, 32'd0);
    write_reg(chtg_pkg::REG_MARKER_LEN, 32'd0);
    write_reg(chtg_pkg::REG_MARKER_HW, 32'd1);
    write_reg(chtg_pkg::REG_OUTLINE, 32'd0);
    write_reg(chtg_pkg::REG_NORMAL_COL, $urandom);
    write_reg(chtg_pkg::REG_ALERT_COL, $urandom);
    random_markers(50, 10240, 7680);
    drain_idle();
    // back to typical values, a zero view width, then a narrow view
    write_reg(chtg_pkg::REG_CULL_MARGIN, 32'd384);
    write_reg(chtg_pkg::REG_MARKER_LEN, 32'd240);
    write_reg(chtg_pkg::REG_MARKER_HW, 32'd88);
    write_reg(chtg_pkg::REG_OUTLINE, 32'd346);
    write_reg(chtg_pkg::REG_VIEW_WIDTH, 32'd0);
    random_markers(5, 1000, 1000);
    drain_idle();
    write_reg(chtg_pkg::REG_VIEW_WIDTH, 32'd200);
    write_reg(chtg_pkg::REG_VIEW_HEIGHT, 32'd150);
    random_markers(90, 3200, 2400);
    drain_idle();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end
endmodule
